/* hw/rtl/pip_pkg.sv */
// Package for the point-in-polygon block: fixed field widths, codes and the
// control word that travels from the command queue to the edge walker.
// Depends on nothing.
package pip_pkg;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Classified command as held in the queue.
    typedef struct packed {
        logic              is_query;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
    } pip_ctl_t;

endpackage

/* hw/rtl/pip_front.sv */
// Front end of the point-in-polygon block: accepts input words, classifies
// them and holds them in a two-entry queue for the edge walker.
// Depends on pip_pkg.
module pip_front #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [pip_pkg::SLOT_W-1:0]     vertex_slot,
    input  logic signed [COORD_BITS-1:0]   coord_x,
    input  logic signed [COORD_BITS-1:0]   coord_z,
    output logic                           q_valid,
    input  logic                           q_pop,
    output pip_pkg::pip_ctl_t              q_ctl,
    output logic signed [COORD_BITS-1:0]   q_x,
    output logic signed [COORD_BITS-1:0]   q_z
);
    import pip_pkg::*;

    pip_ctl_t                   ctl_mem [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] x_mem [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] z_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    pip_ctl_t          ctl_in;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && q_pop;

    // A load to a slot beyond the store is kept in order but writes nothing.
    always_comb
    begin
        ctl_in.is_query = (cmd == CMD_QUERY);
        ctl_in.slot_ok  = (32'(vertex_slot) < 32'(MAX_VERTICES));
        ctl_in.slot     = vertex_slot;
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= ctl_in;
            x_mem[wr_ptr_reg]   <= coord_x;
            z_mem[wr_ptr_reg]   <= coord_z;
        end
    end

    assign q_ctl = ctl_mem[rd_ptr_reg];
    assign q_x   = x_mem[rd_ptr_reg];
    assign q_z   = z_mem[rd_ptr_reg];

endmodule

/* hw/rtl/pip_back.sv */
// Back end of the point-in-polygon block: vertex store, vertex count register,
// edge walker with its multiply and compare pipeline, and the result register.
// Depends on pip_pkg.
module pip_back #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  pip_pkg::pip_ctl_t              q_ctl,
    input  logic signed [COORD_BITS-1:0]   q_x,
    input  logic signed [COORD_BITS-1:0]   q_z,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pip_pkg::COUNT_W-1:0]    cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           inside_res
);
    import pip_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

    state_t            state_reg;
    logic [NW-1:0]     k_reg;
    logic              out_valid_reg;
    logic              inside_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [NW-1:0]     n_eff;
    logic [31:0]       count_wide;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_z [MAX_VERTICES];

    logic              out_free;
    logic              query_go;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              rd_first;
    logic              rd_last;

    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] pz_reg;

    // Read stage.
    logic                          r_vld_reg;
    logic                          r_first_reg;
    logic                          r_last_reg;
    logic signed [COORD_BITS-1:0]  r_x_reg;
    logic signed [COORD_BITS-1:0]  r_z_reg;
    // Previous vertex, the j end of the current edge.
    logic signed [COORD_BITS-1:0]  prev_x_reg;
    logic signed [COORD_BITS-1:0]  prev_z_reg;
    // Difference stage.
    logic                          e_vld_reg;
    logic                          e_last_reg;
    logic                          e_straddle_reg;
    logic                          e_pos_reg;
    logic signed [DW-1:0]          e_d_reg;
    logic signed [DW-1:0]          e_a_reg;
    logic signed [DW-1:0]          e_b_reg;
    logic signed [DW-1:0]          e_c_reg;
    // Product stage.
    logic                          m_vld_reg;
    logic                          m_last_reg;
    logic                          m_straddle_reg;
    logic                          m_pos_reg;
    logic signed [PW-1:0]          m_lhs_reg;
    logic signed [PW-1:0]          m_rhs_reg;

    logic                          inside_acc_reg;
    logic                          left;
    logic                          toggle;
    logic                          finish;
    logic                          res_set;
    logic                          res_val;

    logic signed [DW-1:0]          xi_w;
    logic signed [DW-1:0]          zi_w;
    logic signed [DW-1:0]          xj_w;
    logic signed [DW-1:0]          zj_w;
    logic signed [DW-1:0]          px_w;
    logic signed [DW-1:0]          pz_w;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    // A count above the store depth walks the whole store.
    assign count_wide = 32'(count_reg);
    assign n_eff = (count_wide > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_wide);

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && (!q_ctl.is_query || out_free);
    assign query_go = (state_reg == ST_IDLE) && q_valid && q_ctl.is_query && out_free;
    assign wr_en    = (state_reg == ST_IDLE) && q_valid && !q_ctl.is_query && q_ctl.slot_ok;

    // The walk reads the last vertex first, then vertices 0 to n-1, so each
    // read closes the edge from the vertex read just before it.
    assign rd_en    = (state_reg == ST_ISSUE);
    assign rd_first = (k_reg == '0);
    assign rd_last  = (k_reg == n_eff);
    assign rd_addr  = rd_first ? AW'(n_eff - NW'(1)) : AW'(k_reg - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= COUNT_RESET;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[AW'(q_ctl.slot)] <= q_x;
            mem_z[AW'(q_ctl.slot)] <= q_z;
        end
        if (rd_en)
        begin
            r_x_reg <= mem_x[rd_addr];
            r_z_reg <= mem_z[rd_addr];
        end
    end

    always_comb
    begin
        xi_w = {r_x_reg[COORD_BITS-1], r_x_reg};
        zi_w = {r_z_reg[COORD_BITS-1], r_z_reg};
        xj_w = {prev_x_reg[COORD_BITS-1], prev_x_reg};
        zj_w = {prev_z_reg[COORD_BITS-1], prev_z_reg};
        px_w = {px_reg[COORD_BITS-1], px_reg};
        pz_w = {pz_reg[COORD_BITS-1], pz_reg};
    end

    // Payload side of the pipeline.
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            px_reg <= q_x;
            pz_reg <= q_z;
        end
        if (r_vld_reg)
        begin
            prev_x_reg <= r_x_reg;
            prev_z_reg <= r_z_reg;
        end
        e_straddle_reg <= (r_z_reg > pz_reg) != (prev_z_reg > pz_reg);
        e_pos_reg      <= (prev_z_reg > r_z_reg);
        e_d_reg        <= zj_w - zi_w;
        e_a_reg        <= px_w - xi_w;
        e_b_reg        <= xj_w - xi_w;
        e_c_reg        <= pz_w - zi_w;
        m_straddle_reg <= e_straddle_reg;
        m_pos_reg      <= e_pos_reg;
        m_lhs_reg      <= e_a_reg * e_d_reg;
        m_rhs_reg      <= e_b_reg * e_c_reg;
        r_first_reg    <= rd_first;
        r_last_reg     <= rd_last;
        e_last_reg     <= r_last_reg;
        m_last_reg     <= e_last_reg;
    end

    // The crossing test with the division folded into the sign of d.
    assign left   = m_pos_reg ? (m_lhs_reg < m_rhs_reg) : (m_rhs_reg < m_lhs_reg);
    assign toggle = m_vld_reg && m_straddle_reg && left;
    assign finish = m_vld_reg && m_last_reg;

    // A result is loaded when a query meets an empty polygon or a walk ends.
    always_comb
    begin
        res_set = 1'b0;
        res_val = 1'b0;
        if (query_go && (n_eff == '0))
            res_set = 1'b1;
        else if ((state_reg == ST_DRAIN) && finish)
        begin
            res_set = 1'b1;
            res_val = inside_acc_reg ^ toggle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg      <= 1'b0;
            e_vld_reg      <= 1'b0;
            m_vld_reg      <= 1'b0;
            inside_acc_reg <= 1'b0;
        end
        else
        begin
            r_vld_reg <= rd_en;
            e_vld_reg <= r_vld_reg && !r_first_reg;
            m_vld_reg <= e_vld_reg;
            if (query_go)
                inside_acc_reg <= 1'b0;
            else if (toggle)
                inside_acc_reg <= !inside_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
        end
        else
        begin
            if (res_set)
            begin
                out_valid_reg <= 1'b1;
                inside_reg    <= res_val;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (query_go && (n_eff != '0))
                    begin
                        state_reg <= ST_ISSUE;
                        k_reg     <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    k_reg <= k_reg + NW'(1);
                    if (rd_last)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (finish)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The last edge of a walk only arrives while the walker waits for it.
    a_finish_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (state_reg == ST_DRAIN))
        else $error("walk finished outside the drain state");

    // A finished walk always finds the result register free.
    a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> out_free)
        else $error("result overwrote a word still waiting");

    // Only one query is ever in the pipeline.
    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({r_vld_reg && r_last_reg, e_vld_reg && e_last_reg, finish}))
        else $error("more than one walk in flight");

    // The pipeline is empty whenever the walker is idle.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(r_vld_reg || e_vld_reg || m_vld_reg))
        else $error("edge pipeline busy while idle");

    // No store write and no queue pop take place during a walk.
    a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !wr_en && !q_pop)
        else $error("queue served during a walk");
`endif

endmodule

/* hw/rtl/point_in_polygon_ray_cast.sv */
// Even-odd point-in-polygon test by ray casting, built from pip_front (command queue)
// and pip_back (vertex store and edge walker). A load writes the store while the walker
// is idle. A query with n vertices in use (count saturated at the store depth) holds the
// walker for a pop, n+1 store reads and a three-stage drain; for a count of zero its word
// is loaded straight from the pop, with no walk. Reset is asynchronous, active low,
// clears control state and sets vertex_count to 3; the store is not cleared.
module point_in_polygon_ray_cast #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [pip_pkg::SLOT_W-1:0]     vertex_slot,
    input  logic signed [COORD_BITS-1:0]   coord_x,
    input  logic signed [COORD_BITS-1:0]   coord_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           inside_res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pip_pkg::COUNT_W-1:0]    cfg_data
);
    import pip_pkg::*;

    // The queue between the two halves lets new words come in while a walk
    // runs or while a finished result waits for the consumer. Loads travel
    // through the same queue as queries, so a load always lands after every
    // query that was accepted before it.
    logic                           q_valid;
    logic                           q_pop;
    pip_ctl_t                       q_ctl;
    logic signed [COORD_BITS-1:0]   q_x;
    logic signed [COORD_BITS-1:0]   q_z;

    pip_front #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .vertex_slot(vertex_slot),
        .coord_x    (coord_x),
        .coord_z    (coord_z),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_ctl      (q_ctl),
        .q_x        (q_x),
        .q_z        (q_z)
    );

    // The walker reads one vertex per cycle from a single-port store, forms
    // the edge from the previous vertex, multiplies both sides of the crossing
    // test in parallel and compares them exactly, so no division is needed.
    pip_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctl     (q_ctl),
        .q_x       (q_x),
        .q_z       (q_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .inside_res(inside_res)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for point_in_polygon_ray_cast: a directed table, then random polygons
// and queries checked against an even-odd crossing predictor kept in the bench.
// Depends on pip_pkg and the RTL of the block; nothing else.
module tb_top;
    import pip_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 45;
    localparam int PHASES        = 18;
    localparam int REPORT_MAX    = 10;

    localparam logic signed [23:0] C_MIN = 24'sh800000;
    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;
    typedef enum logic [1:0] {SCALE_TIGHT, SCALE_MID, SCALE_FULL} scale_t;

    typedef struct {
        row_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
        logic signed [23:0] x;
        logic signed [23:0] z;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        bit                 want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  cmd         = CMD_LOAD;
    logic [SLOT_W-1:0]     vertex_slot = '0;
    logic signed [23:0]    coord_x     = '0;
    logic signed [23:0]    coord_z     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  inside_res;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data    = '0;

    // Bench copy of the block's state: vertex store and vertex count.
    logic signed [23:0]    vert_x [STORE_DEPTH];
    logic signed [23:0]    vert_z [STORE_DEPTH];
    logic [COUNT_W-1:0]    walk_count = COUNT_RESET;

    // Inside flags still owed by the block, oldest first.
    bit                    inside_q [$];

    int                    mismatch_count = 0;
    int                    send_idle_pct  = 0;
    int                    recv_idle_pct  = 0;
    int                    hold_asked     = 0;
    int                    hold_seen      = 0;
    int                    hold_left      = 0;
    int                    cycle_no       = 0;

    point_in_polygon_ray_cast DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .vertex_slot (vertex_slot),
        .coord_x     (coord_x),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Even-odd count over all edges in use. Differences fit in 25 bits, so the
    // cross products fit easily in 64 bits and the compare is exact.
    function automatic bit predict_inside(input logic signed [23:0] px,
                                          input logic signed [23:0] pz);
        int      n;
        int      j;
        longint  lpx;
        longint  lpz;
        longint  xi;
        longint  zi;
        longint  xj;
        longint  zj;
        longint  d;
        longint  lhs;
        longint  rhs;
        bit      in_flag;
        bit      left;
        n = (walk_count > STORE_DEPTH) ? STORE_DEPTH : walk_count;
        in_flag = 1'b0;
        lpx = px;
        lpz = pz;
        if (n == 0)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            xi = vert_x[i];
            zi = vert_z[i];
            xj = vert_x[j];
            zj = vert_z[j];
            // Only edges that strictly straddle the point's z can count.
            if ((zi > lpz) != (zj > lpz))
            begin
                d = zj - zi;
                lhs = (lpx - xi) * d;
                rhs = (xj - xi) * (lpz - zi);
                // The sign of d decides which way the divided form flips.
                left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    in_flag = !in_flag;
            end
            j = i;
        end
        return in_flag;
    endfunction

    function automatic logic signed [23:0] rand_coord(input scale_t scale);
        int v;
        case (scale)
            SCALE_TIGHT: v = int'($urandom_range(64)) - 32;
            SCALE_MID:   v = int'($urandom_range(8192)) - 4096;
            default:     v = int'($urandom());
        endcase
        return v[23:0];
    endfunction

    // Offer one word on the input channel and hold it until the block takes it.
    // Valid stays high after acceptance until an idle in a later call, a count write or the end of the test lowers it.
    task automatic offer_word(input logic c, input logic [SLOT_W-1:0] s,
                              input logic signed [23:0] x, input logic signed [23:0] z,
                              input bit typed, input bit want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        vertex_slot <= s;
        coord_x     <= x;
        coord_z     <= z;
        do
            @(posedge clk);
        while (in_stall);
        if (c == CMD_LOAD)
        begin
            vert_x[s] = x;
            vert_z[s] = z;
        end
        else
            inside_q.insert(inside_q.size(), typed ? want : predict_inside(x, z));
    endtask

    // The count may only change while the block is idle. A load leaves no
    // word behind, so after the last query word the bench still waits for
    // any trailing loads to clear the walker.
    task automatic write_count(input logic [COUNT_W-1:0] v);
        in_valid <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        walk_count = v;
    endtask

    // Output side: check each accepted word against the oldest expectation,
    // then pick the stall for the next cycle, including the long hold-off.
    always @(posedge clk)
    begin : result_side
        bit owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (inside_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected word: inside_res %0d with nothing owed", inside_res);
            end
            else
            begin
                owed = inside_q.pop_front();
                if (inside_res !== owed)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("wrong inside_res: expected %0d got %0d", owed, inside_res);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("point_in_polygon_ray_cast: mismatch");
            $finish;
        end
    end

    initial
    begin
        dir_row_t           rows [$];
        dir_row_t           r;
        int                 phase_counts [PHASES];
        int                 n_used;
        int                 a;
        int                 b;
        scale_t             scale;
        logic [SLOT_W-1:0]  s;
        logic signed [23:0] qx;
        logic signed [23:0] qz;

        // Directed table. The first three loads make a triangle for the reset
        // count of three, built from the coordinate extremes.
        rows.insert(rows.size(), '{ROW_LOAD, 6'd0, C_MIN, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_LOAD, 6'd1, C_MAX, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_LOAD, 6'd2, C_MAX, C_MAX, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b0, 1'b0});
        // Point exactly on the right edge's crossing: not left of it.
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, C_MAX, 24'sd0, 7'd0, 1'b0, 1'b0});
        // Point on a vertex, then on the z of the horizontal bottom edge.
        rows.insert(rows.size(), '{ROW_QUERY, 6'd63, C_MIN, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_LOAD, 6'd3, C_MIN, C_MAX, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_LOAD, 6'd63, -24'sd1, -24'sd1, 7'd0, 1'b0, 1'b0});
        // Full square from the four extreme corners.
        rows.insert(rows.size(), '{ROW_COUNT, 6'd0, 24'sd0, 24'sd0, 7'd4, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, C_MIN, 24'sd0, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, C_MAX, C_MAX, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, C_MIN, -24'sd1, 7'd0, 1'b0, 1'b0});
        // Counts below three can never report inside.
        rows.insert(rows.size(), '{ROW_COUNT, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b1, 1'b0});
        rows.insert(rows.size(), '{ROW_COUNT, 6'd0, 24'sd0, 24'sd0, 7'd1, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b1, 1'b0});
        rows.insert(rows.size(), '{ROW_COUNT, 6'd0, 24'sd0, 24'sd0, 7'd2, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, 24'sd0, 7'd0, 1'b1, 1'b0});
        // Flatten the triangle: every edge is horizontal at the bottom z.
        rows.insert(rows.size(), '{ROW_COUNT, 6'd0, 24'sd0, 24'sd0, 7'd3, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_LOAD, 6'd2, 24'sd0, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, 24'sd0, C_MIN, 7'd0, 1'b0, 1'b0});
        rows.insert(rows.size(), '{ROW_QUERY, 6'd0, C_MIN, C_MAX, 7'd0, 1'b0, 1'b0});

        // Counts for the random phases; mostly small polygons, with the full
        // store and the saturating count of 127 a few times.
        phase_counts = '{64, 127, 5, 3, 4, 8, 3, 6, 12, 64, 4, 7, 3, 33, 5, 10, 4, 127};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 74;
        foreach (rows[k])
        begin
            r = rows[k];
            case (r.kind)
                ROW_COUNT: write_count(r.count);
                ROW_LOAD:  offer_word(CMD_LOAD, r.slot, r.x, r.z, 1'b0, 1'b0);
                default:   offer_word(CMD_QUERY, r.slot, r.x, r.z, r.typed, r.want);
            endcase
        end

        // Write every slot so that no later count reaches an unwritten entry.
        for (int k = 0; k < STORE_DEPTH; k++)
            offer_word(CMD_LOAD, k[SLOT_W-1:0], rand_coord(SCALE_FULL), rand_coord(SCALE_MID),
                       1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 6)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 74;
            end
            else if (p < 12)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_count(phase_counts[p][COUNT_W-1:0]);
            // Long receiver hold-off while the sender keeps offering words,
            // so the command queue fills and the input stalls.
            if (p == 2 || p == 14)
                hold_asked <= hold_asked + 1;
            n_used = (walk_count > STORE_DEPTH) ? STORE_DEPTH : walk_count;
            scale = scale_t'(p % 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 35)
                begin
                    if ($urandom_range(3) == 0)
                        s = SLOT_W'($urandom_range(STORE_DEPTH - 1));
                    else
                        s = SLOT_W'($urandom_range(n_used - 1));
                    offer_word(CMD_LOAD, s, rand_coord(scale), rand_coord(scale), 1'b0, 1'b0);
                end
                else
                begin
                    qx = rand_coord(scale);
                    qz = rand_coord(scale);
                    a = int'($urandom_range(n_used - 1));
                    b = (a + 1) % n_used;
                    case ($urandom_range(9))
                        0: qz = vert_z[a];
                        1:
                        begin
                            qx = vert_x[a];
                            qz = vert_z[a];
                        end
                        2:
                        begin
                            qx = rand_coord(SCALE_FULL);
                            qz = rand_coord(SCALE_FULL);
                        end
                        3:
                        begin
                            // Midpoint of an edge, often exactly on it.
                            qx = 24'((longint'(vert_x[a]) + longint'(vert_x[b])) >>> 1);
                            qz = 24'((longint'(vert_z[a]) + longint'(vert_z[b])) >>> 1);
                        end
                        default: ;
                    endcase
                    offer_word(CMD_QUERY, SLOT_W'($urandom_range(STORE_DEPTH - 1)), qx, qz,
                               1'b0, 1'b0);
                end
            end
        end

        in_valid <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("point_in_polygon_ray_cast: match");
        else
            $display("point_in_polygon_ray_cast: mismatch");
        $finish;
    end

endmodule
